// File: rtl/scsb_pkg.sv
// ----------------------------------------------------------------------------
// Sorted color signature buffer package
// Shared constants, codes, control structs and the order merge function.
// ----------------------------------------------------------------------------
package scsb_pkg;

   localparam int DEPTH_DEF      = 64;
   localparam int COLOR_BITS_DEF = 16;
   localparam int COLOR_W        = 16;
   localparam int COUNT_W        = 7;

   // Action codes of an input beat.
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_END    = 1'b1;

   // Order codes, two's complement: -1 less, 0 equal, +1 greater.
   localparam logic [1:0] ORD_EQ = 2'b00;
   localparam logic [1:0] ORD_GT = 2'b01;
   localparam logic [1:0] ORD_LT = 2'b11;

   typedef enum logic {
      STATE_IDLE,
      STATE_REDUCE
   } state_type;

   typedef struct packed {
      logic insert;
      logic swap;
   } cell_ctl_type;

   typedef struct packed {
      logic [1:0]         order;
      logic               unchanged;
      logic               overflow;
      logic [COUNT_W-1:0] count;
   } result_type;

   // The earlier position decides unless it found its pair equal.
   function automatic logic [1:0] ord_merge(logic [1:0] first, logic [1:0] second);
      return (first != ORD_EQ) ? first : second;
   endfunction

endpackage

// File: rtl/sorted_color_signature_buffer.sv
// ----------------------------------------------------------------------------
// Sorted color signature buffer
// Sorted insertion list of neighbor colors with an end-of-round
// lexicographic compare against the previous round's list in normal mode.
// ----------------------------------------------------------------------------
// An insert beat's result passes the result register, then the output
// register; no new beat is taken while the result register holds a result.
// An end-of-round beat in normal mode waits for the verdict reduction, which
// folds one tree level per cycle; polarity-node mode skips the reduction.
// Reset (synchronous, active high) empties both lists and clears the mode.
// ----------------------------------------------------------------------------
module sorted_color_signature_buffer #(
   parameter int DEPTH      = scsb_pkg::DEPTH_DEF,
   parameter int COLOR_BITS = scsb_pkg::COLOR_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // Configuration port.
   input  logic                         csr_we,
   input  logic                         csr_wdata,
   // Request channel.
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_action,
   input  logic [scsb_pkg::COLOR_W-1:0] req_color,
   // Response channel.
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [1:0]            rsp_order,
   output logic                         rsp_unchanged,
   output logic                         rsp_overflow,
   output logic [scsb_pkg::COUNT_W-1:0] rsp_count
);
   import scsb_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   // Polarity-node mode register.
   logic mode_ff;

   // List occupancy.
   logic [CNT_W-1:0] cur_count_ff, cur_count_in;
   logic [CNT_W-1:0] prev_count_ff, prev_count_in;
   logic [1:0]       cnt_ord_ff, cnt_ord_in;
   logic             full;

   // Control.
   state_type    state_ff, state_in;
   logic         accept;
   cell_ctl_type ctl;

   // Finished result waiting for the output register, and the output register.
   logic       res_valid_ff, res_valid_in;
   result_type res_ff, res_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic       move;

   // Cell chain signals.
   logic [31:0]           color_wide;
   logic [COLOR_BITS-1:0] color;
   logic [COLOR_BITS-1:0] chain_color   [DEPTH];
   logic                  chain_greater [DEPTH];
   logic [1:0]            verdict       [DEPTH];
   logic                  red_done;
   logic [1:0]            red_verdict;
   logic [1:0]            final_ord;
   logic [31:0]           cnt_wide;

   // Colors wider than COLOR_BITS are masked before they are stored.
   assign color_wide = 32'(req_color);
   assign color      = color_wide[COLOR_BITS-1:0];

   assign full      = (cur_count_ff == CNT_W'(DEPTH));
   assign req_ready = (state_ff == STATE_IDLE) && !res_valid_ff;
   assign accept    = req_valid && req_ready;

   assign ctl.insert = accept && (req_action == ACT_INSERT) && !full;
   assign ctl.swap   = accept && (req_action == ACT_END) && !mode_ff;

   // The chain: each cell looks at its left neighbor's color and compare
   // outcome, so all cells update together on a sorted insert.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [COLOR_BITS-1:0] left_color;
      logic                  left_greater;
      if (i == 0) begin : g_head
         assign left_color   = '0;
         assign left_greater = 1'b0;
      end else begin : g_body
         assign left_color   = chain_color[i-1];
         assign left_greater = chain_greater[i-1];
      end
      scsb_cell #(
         .IDX        (i),
         .CNT_W      (CNT_W),
         .COLOR_BITS (COLOR_BITS)
      ) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .color        (color),
         .left_color   (left_color),
         .left_greater (left_greater),
         .cur_count    (cur_count_ff),
         .prev_count   (prev_count_ff),
         .cur_color    (chain_color[i]),
         .greater      (chain_greater[i]),
         .verdict      (verdict[i])
      );
   end

   // Verdicts are captured in the same cycle that the lists swap, so the
   // reduction works on the old lists while the cells already hold the new.
   scsb_reduce #(
      .DEPTH (DEPTH)
   ) u_reduce (
      .clock       (clock),
      .reset       (reset),
      .load        (ctl.swap),
      .verdict_in  (verdict),
      .done        (red_done),
      .verdict_out (red_verdict)
   );

   // When the common prefix matches, the shorter list is the lesser.
   assign final_ord = ord_merge(red_verdict, cnt_ord_ff);
   assign cnt_wide  = 32'(cur_count_in);
   assign move      = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cur_count_in  = cur_count_ff;
      prev_count_in = prev_count_ff;
      cnt_ord_in    = cnt_ord_ff;
      res_valid_in  = res_valid_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (move) begin
         rsp_valid_in = res_valid_ff;
         res_valid_in = 1'b0;
      end

      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               if (req_action == ACT_INSERT) begin
                  if (!full) begin
                     cur_count_in = cur_count_ff + CNT_W'(1);
                  end
               end else begin
                  cur_count_in = '0;
               end
               res_in.order     = ORD_EQ;
               res_in.unchanged = 1'b0;
               res_in.overflow  = (req_action == ACT_INSERT) && full;
               res_in.count     = cnt_wide[COUNT_W-1:0];
               if (ctl.swap) begin
                  prev_count_in = cur_count_ff;
                  if (cur_count_ff < prev_count_ff) begin
                     cnt_ord_in = ORD_LT;
                  end else if (cur_count_ff > prev_count_ff) begin
                     cnt_ord_in = ORD_GT;
                  end else begin
                     cnt_ord_in = ORD_EQ;
                  end
                  state_in = STATE_REDUCE;
               end else begin
                  res_valid_in = 1'b1;
               end
            end
         end
         STATE_REDUCE: begin
            if (red_done) begin
               res_in.order     = final_ord;
               res_in.unchanged = (final_ord == ORD_EQ);
               res_in.overflow  = 1'b0;
               res_in.count     = '0;
               res_valid_in     = 1'b1;
               state_in         = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (move) begin
         rsp_ff <= res_ff;
      end
      if (reset) begin
         mode_ff       <= 1'b0;
         state_ff      <= STATE_IDLE;
         cur_count_ff  <= '0;
         prev_count_ff <= '0;
         cnt_ord_ff    <= ORD_EQ;
         res_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         state_ff      <= state_in;
         cur_count_ff  <= cur_count_in;
         prev_count_ff <= prev_count_in;
         cnt_ord_ff    <= cnt_ord_in;
         res_valid_ff  <= res_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_order     = signed'(rsp_ff.order);
   assign rsp_unchanged = rsp_ff.unchanged;
   assign rsp_overflow  = rsp_ff.overflow;
   assign rsp_count     = rsp_ff.count;

   // The occupancy count never runs past the list depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cur_count_ff <= CNT_W'(DEPTH))
      else $error("current count exceeds depth");

   // The reduction only finishes while the controller waits for it.
   a_done_in_reduce: assert property (@(posedge clock) disable iff (reset)
      red_done |-> (state_ff == STATE_REDUCE))
      else $error("reduction finished outside the compare state");

   // An insert into a full list yields a dropped-beat result next cycle.
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == ACT_INSERT) && full)
      |=> (res_valid_ff && res_ff.overflow && (cur_count_ff == CNT_W'(DEPTH))))
      else $error("full insert not reported as overflow");

   // An unchanged result is always an end-of-round result with equal order.
   a_unchanged: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.unchanged)
      |-> ((rsp_ff.order == ORD_EQ) && (rsp_ff.count == '0) && !rsp_ff.overflow))
      else $error("unchanged flag with inconsistent result");

endmodule

// File: rtl/scsb_cell.sv
// ----------------------------------------------------------------------------
// Sorted color signature buffer cell
// One list position: current and previous color, insert shift and verdict.
// ----------------------------------------------------------------------------
module scsb_cell #(
   parameter int IDX        = 0,
   parameter int CNT_W      = 7,
   parameter int COLOR_BITS = 16
) (
   input  logic                   clock,
   input  scsb_pkg::cell_ctl_type ctl,
   input  logic [COLOR_BITS-1:0]  color,
   input  logic [COLOR_BITS-1:0]  left_color,
   input  logic                   left_greater,
   input  logic [CNT_W-1:0]       cur_count,
   input  logic [CNT_W-1:0]       prev_count,
   output logic [COLOR_BITS-1:0]  cur_color,
   output logic                   greater,
   output logic [1:0]             verdict
);
   import scsb_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic [COLOR_BITS-1:0] cur_ff, cur_in;
   logic [COLOR_BITS-1:0] prev_ff;
   logic                  in_range;

   assign cur_color = cur_ff;
   assign greater   = (MY_IDX < cur_count) && (cur_ff > color);
   assign in_range  = (MY_IDX < cur_count) && (MY_IDX < prev_count);

   // The new color lands in the first cell holding a larger entry, or at the
   // tail; every larger entry moves one cell to the right, the last one into
   // the tail cell.
   always_comb begin
      cur_in = cur_ff;
      if (ctl.insert) begin
         if (greater) begin
            cur_in = left_greater ? left_color : color;
         end else if (MY_IDX == cur_count) begin
            cur_in = left_greater ? left_color : color;
         end
      end
   end

   always_comb begin
      if (!in_range) begin
         verdict = ORD_EQ;
      end else if (cur_ff < prev_ff) begin
         verdict = ORD_LT;
      end else if (cur_ff > prev_ff) begin
         verdict = ORD_GT;
      end else begin
         verdict = ORD_EQ;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (ctl.swap) begin
         prev_ff <= cur_ff;
      end
   end

endmodule

// File: rtl/scsb_reduce.sv
// ----------------------------------------------------------------------------
// Sorted color signature buffer verdict reduction
// Folds the per-cell verdicts pairwise, one tree level per cycle.
// ----------------------------------------------------------------------------
module scsb_reduce #(
   parameter int DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic [1:0] verdict_in [DEPTH],
   output logic       done,
   output logic [1:0] verdict_out
);
   import scsb_pkg::*;

   localparam int LEVELS = $clog2(DEPTH);
   localparam int P      = 1 << LEVELS;
   localparam int LVL_W  = (LEVELS > 0) ? $clog2(LEVELS + 1) : 1;

   logic [1:0]       v_ff [P];
   logic [1:0]       v_in [P];
   logic             busy_ff, busy_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic             last;

   assign last        = (lvl_ff == LVL_W'(LEVELS));
   assign done        = busy_ff && last;
   assign verdict_out = v_ff[0];

   always_comb begin
      v_in    = v_ff;
      busy_in = busy_ff;
      lvl_in  = lvl_ff;
      if (load) begin
         for (int j = 0; j < DEPTH; j++) begin
            v_in[j] = verdict_in[j];
         end
         for (int j = DEPTH; j < P; j++) begin
            v_in[j] = ORD_EQ;
         end
         busy_in = 1'b1;
         lvl_in  = '0;
      end else if (busy_ff) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            for (int j = 0; j < P / 2; j++) begin
               v_in[j] = ord_merge(v_ff[2*j], v_ff[2*j+1]);
            end
            lvl_in = lvl_ff + LVL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      if (reset) begin
         busy_ff <= 1'b0;
         lvl_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         lvl_ff  <= lvl_in;
      end
   end

endmodule
